// ===== rtl/core/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, operation and status codes,
// and the controller/datapath command enum and status struct. No dependencies.
package rau_pkg;
   localparam int NumWidth = 32;
   localparam int DenWidth = NumWidth - 1;
   localparam int WideWidth = 64;
   localparam int CntWidth = 7;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_LT  = 3'd4
   } mode_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL1,
      CMD_MUL2,
      CMD_MUL3,
      CMD_COMBINE,
      CMD_GCD_INIT,
      CMD_GCD_STEP,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic early;
      logic gcd_done;
      logic div_done;
   } dp_status_type;
endpackage

// ===== rtl/core/rational_arith_unit.sv =====
// Rational arithmetic unit: add, subtract, multiply, divide, compare, reduce.
// An undefined mode or a zero divisor goes straight to the response, less-than
// ends once the cross products are compared, a zero result after the gcd setup;
// otherwise three multiplier steps, the gcd and two restoring divisions run.
// One request at a time; the next is taken in the cycle after the
// response is consumed. Synchronous active-high reset returns control to idle.
module rational_arith_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata, // a_num[31:0] a_den[62:32] b_num[94:63] b_den[125:95] pad
   input  logic [2:0]   req_tuser, // mode[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata  // res_num[31:0] res_den[62:32] is_less[63] status[65:64] pad
);
   import rau_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;
   logic          busy;
   logic [NumWidth-1:0] res_num;
   logic [DenWidth-1:0] res_den;
   logic          res_less;
   logic [1:0]    res_status;

   rau_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready),
      .rsp_fire(rsp_tvalid && rsp_tready),
      .dp_status(dp_status), .cmd(cmd), .busy(busy), .rsp_valid(rsp_tvalid)
   );

   rau_datapath u_dp (
      .clock(clock), .cmd(cmd),
      .mode(req_tuser), .a_num(req_tdata[31:0]), .a_den(req_tdata[62:32]),
      .b_num(req_tdata[94:63]), .b_den(req_tdata[125:95]),
      .status_out(dp_status), .res_num(res_num), .res_den(res_den),
      .res_less(res_less), .res_status(res_status)
   );

   assign req_tready = !busy;
   assign rsp_tdata = {6'd0, res_status, res_less, res_den, res_num};
endmodule

// ===== rtl/core/rau_datapath.sv =====
// Datapath: operand registers, one 33x33 signed multiplier, binary gcd and a shared
// restoring divider that quotients numerator and denominator by the gcd.
// Depends on rau_pkg.
module rau_datapath (
   input  logic                      clock,
   input  rau_pkg::cmd_type          cmd,
   input  logic [2:0]                mode,
   input  logic [rau_pkg::NumWidth-1:0] a_num,
   input  logic [rau_pkg::DenWidth-1:0] a_den,
   input  logic [rau_pkg::NumWidth-1:0] b_num,
   input  logic [rau_pkg::DenWidth-1:0] b_den,
   output rau_pkg::dp_status_type    status_out,
   output logic [rau_pkg::NumWidth-1:0] res_num,
   output logic [rau_pkg::DenWidth-1:0] res_den,
   output logic                      res_less,
   output logic [1:0]                res_status
);
   import rau_pkg::*;

   logic [2:0]            mode_ff;
   logic [NumWidth-1:0]   an_ff, bn_ff;
   logic [DenWidth-1:0]   ad_ff, bd_ff;
   logic signed [WideWidth-1:0] p1_ff, p2_ff, p3_ff;
   logic                  neg_ff;
   logic [WideWidth-1:0]  nm_ff, dm_ff;
   logic [WideWidth-1:0]  gx_ff, gy_ff;
   logic [CntWidth-1:0]   shift_ff;
   logic [WideWidth-1:0]  g_ff;
   logic                  div_sel_ff;
   logic [WideWidth-1:0]  rem_ff, quo_ff;
   logic [CntWidth-1:0]   cnt_ff;
   logic                  div_done_ff;
   logic                  early_ff;
   logic [NumWidth-1:0]   rn_ff;
   logic [DenWidth-1:0]   rd_ff;
   logic                  rl_ff;
   logic [1:0]            rs_ff;

   logic signed [NumWidth:0] mop_a, mop_b;
   logic signed [2*NumWidth+1:0] mprod;
   logic signed [WideWidth-1:0] n_s, d_s;
   logic [WideWidth-1:0]  gdiff;
   logic [WideWidth:0]    rem_sh;
   logic [WideWidth-1:0]  dividend;
   logic [WideWidth-1:0]  lim;

   always_comb begin
      mop_a = '0;
      mop_b = '0;
      unique case (cmd)
         CMD_MUL1: begin
            mop_a = {an_ff[NumWidth-1], an_ff};
            mop_b = (mode_ff == MODE_MUL) ? {bn_ff[NumWidth-1], bn_ff} : {2'b00, bd_ff};
         end
         CMD_MUL2: begin
            mop_a = {bn_ff[NumWidth-1], bn_ff};
            mop_b = {2'b00, ad_ff};
         end
         CMD_MUL3: begin
            mop_a = {2'b00, ad_ff};
            mop_b = (mode_ff == MODE_DIV) ? {bn_ff[NumWidth-1], bn_ff} : {2'b00, bd_ff};
         end
         default: begin
            mop_a = '0;
            mop_b = '0;
         end
      endcase
   end

   assign mprod = mop_a * mop_b;

   always_comb begin
      unique case (mode_ff)
         MODE_ADD: n_s = p1_ff + p2_ff;
         MODE_SUB: n_s = p1_ff - p2_ff;
         default:  n_s = p1_ff;
      endcase
      d_s = p3_ff;
   end

   assign gdiff = (gx_ff > gy_ff) ? gx_ff - gy_ff : gy_ff - gx_ff;
   assign dividend = div_sel_ff ? dm_ff : nm_ff;
   assign rem_sh = {rem_ff, quo_ff[WideWidth-1]};
   assign lim = WideWidth'(1) << (NumWidth - 1);

   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_LOAD: begin
            mode_ff <= mode;
            an_ff <= a_num;
            ad_ff <= a_den;
            bn_ff <= b_num;
            bd_ff <= b_den;
            rn_ff <= '0;
            rd_ff <= DenWidth'(1);
            rl_ff <= 1'b0;
            if (mode > MODE_LT) begin
               early_ff <= 1'b1;
               rs_ff <= ST_OK;
            end else if (a_den == '0 || b_den == '0 ||
                         (mode == MODE_DIV && b_num == '0)) begin
               early_ff <= 1'b1;
               rs_ff <= ST_DIV0;
            end else begin
               early_ff <= 1'b0;
               rs_ff <= ST_OK;
            end
         end
         CMD_MUL1: p1_ff <= mprod[WideWidth-1:0];
         CMD_MUL2: p2_ff <= mprod[WideWidth-1:0];
         CMD_MUL3: p3_ff <= mprod[WideWidth-1:0];
         CMD_COMBINE: begin
            neg_ff <= n_s[WideWidth-1] ^ d_s[WideWidth-1];
            nm_ff <= n_s[WideWidth-1] ? WideWidth'(-n_s) : WideWidth'(n_s);
            dm_ff <= d_s[WideWidth-1] ? WideWidth'(-d_s) : WideWidth'(d_s);
            if (mode_ff == MODE_LT) begin
               rl_ff <= (p1_ff < p2_ff);
               early_ff <= 1'b1;
            end
         end
         CMD_GCD_INIT: begin
            gx_ff <= nm_ff;
            gy_ff <= dm_ff;
            shift_ff <= '0;
            div_sel_ff <= 1'b0;
            if (nm_ff == '0) begin
               early_ff <= 1'b1;
            end
         end
         CMD_GCD_STEP: begin
            if (gx_ff == gy_ff || gy_ff == '0) begin
               g_ff <= gx_ff << shift_ff;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_ff <= gx_ff >> 1;
               gy_ff <= gy_ff >> 1;
               shift_ff <= shift_ff + CntWidth'(1);
            end else if (!gx_ff[0]) begin
               gx_ff <= gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_ff <= gy_ff >> 1;
            end else if (gx_ff > gy_ff) begin
               gx_ff <= gdiff >> 1;
            end else begin
               gy_ff <= gdiff >> 1;
            end
         end
         CMD_DIV_INIT: begin
            rem_ff <= '0;
            quo_ff <= dividend;
            cnt_ff <= '0;
            div_done_ff <= 1'b0;
         end
         CMD_DIV_STEP: begin
            if (rem_sh >= {1'b0, g_ff}) begin
               rem_ff <= WideWidth'(rem_sh - {1'b0, g_ff});
               quo_ff <= {quo_ff[WideWidth-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[WideWidth-1:0];
               quo_ff <= {quo_ff[WideWidth-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + CntWidth'(1);
            if (cnt_ff == CntWidth'(WideWidth - 1)) begin
               div_done_ff <= 1'b1;
               div_sel_ff <= ~div_sel_ff;
               if (!div_sel_ff) nm_ff <= {quo_ff[WideWidth-2:0], rem_sh >= {1'b0, g_ff}};
               else dm_ff <= {quo_ff[WideWidth-2:0], rem_sh >= {1'b0, g_ff}};
            end
         end
         CMD_FINISH: begin
            if ((neg_ff ? (nm_ff > lim) : (nm_ff > lim - WideWidth'(1))) ||
                dm_ff > lim - WideWidth'(1)) begin
               rs_ff <= ST_OVF;
            end else begin
               rn_ff <= neg_ff ? NumWidth'(-nm_ff) : NumWidth'(nm_ff);
               rd_ff <= DenWidth'(dm_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign status_out.early = early_ff;
   assign status_out.gcd_done = (gx_ff == gy_ff) || (gy_ff == '0);
   assign status_out.div_done = div_done_ff;
   assign res_num = rn_ff;
   assign res_den = rd_ff;
   assign res_less = rl_ff;
   assign res_status = rs_ff;
endmodule

// ===== rtl/core/rau_control.sv =====
// Controller: sequences load, products, gcd, two divisions and output hold.
// Depends on rau_pkg.
module rau_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   rsp_fire,
   input  rau_pkg::dp_status_type dp_status,
   output rau_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GINIT, S_GCD,
      S_DINIT, S_DIV, S_DGAP, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;

   always_comb begin
      state_in = state_ff;
      second_in = second_ff;
      cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            cmd = CMD_LOAD;
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = dp_status.early ? S_OUT : S_MUL1;
         end
         S_MUL1: begin
            cmd = CMD_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd = CMD_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd = CMD_MUL3;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd = CMD_COMBINE;
            state_in = S_GINIT;
         end
         S_GINIT: begin
            if (dp_status.early) state_in = S_OUT;
            else begin
               cmd = CMD_GCD_INIT;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            cmd = CMD_GCD_STEP;
            if (dp_status.early) state_in = S_OUT;
            else if (dp_status.gcd_done) begin
               second_in = 1'b0;
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd = CMD_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (dp_status.div_done) state_in = S_DGAP;
            else cmd = CMD_DIV_STEP;
         end
         S_DGAP: begin
            if (second_ff) state_in = S_FIN;
            else begin
               second_in = 1'b1;
               state_in = S_DINIT;
            end
         end
         S_FIN: begin
            cmd = CMD_FINISH;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         second_ff <= second_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule
